### rtl/core/glfsc_pkg.sv
`timescale 1ns / 1ps

package glfsc_pkg;

   // Frame layout
   localparam logic [7:0] SYNC0 = 8'hAA;
   localparam logic [7:0] SYNC1 = 8'h44;
   localparam logic [7:0] SYNC2 = 8'h12;
   localparam int HEADER_LEN = 28;
   localparam int HDR_ID_LO   = 4;
   localparam int HDR_ID_HI   = 5;
   localparam int HDR_LEN_LO  = 8;
   localparam int HDR_LEN_HI  = 9;
   localparam int HDR_WEEK_LO = 14;
   localparam int HDR_WEEK_HI = 15;
   localparam int HDR_MS_B0   = 16;
   localparam int HDR_MS_B3   = 19;
   localparam logic [14:0] LEN_SAT = 15'h7FFF;

   // Register map
   localparam int CSR_AW = 5;
   localparam logic [2:0] REG_POLY = 3'd0;
   localparam logic [2:0] REG_OBS  = 3'd1;
   localparam logic [2:0] REG_GPS  = 3'd2;
   localparam logic [2:0] REG_BDS  = 3'd3;
   localparam logic [2:0] REG_IONO = 3'd4;

   localparam logic [31:0] POLY_RST = 32'hEDB88320;
   localparam logic [15:0] OBS_RST  = 16'd43;
   localparam logic [15:0] GPS_RST  = 16'd7;
   localparam logic [15:0] BDS_RST  = 16'd1696;
   localparam logic [15:0] IONO_RST = 16'd8;

   // Result codes
   localparam logic KIND_BODY    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [2:0] CLASS_OBS   = 3'd0;
   localparam logic [2:0] CLASS_GPS   = 3'd1;
   localparam logic [2:0] CLASS_BDS   = 3'd2;
   localparam logic [2:0] CLASS_IONO  = 3'd3;
   localparam logic [2:0] CLASS_OTHER = 3'd4;

   localparam logic [1:0] STAT_GOOD = 2'd0;
   localparam logic [1:0] STAT_CRC  = 2'd1;
   localparam logic [1:0] STAT_LEN  = 2'd2;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_BODY    = 4'b0100,
      PH_TRAILER = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [31:0] poly;
      logic [31:0] seed;   // CRC after the first two sync bytes
      logic [15:0] obs_id;
      logic [15:0] gps_id;
      logic [15:0] bds_id;
      logic [15:0] iono_id;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  body_byte;
      logic [13:0] body_index;
      logic [15:0] message_id;
      logic [2:0]  message_class;
      logic [14:0] body_length;
      logic [15:0] gps_week;
      logic [31:0] week_ms;
      logic [1:0]  status;
   } rsp_type;

   // Reflected CRC-32, one byte, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b,
                                            input logic [31:0] poly);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
      end
      return c;
   endfunction

   // CRC from zero over the first two sync bytes
   function automatic logic [31:0] sync_seed(input logic [31:0] poly);
      return crc_byte(crc_byte(32'h0, SYNC0, poly), SYNC1, poly);
   endfunction

endpackage

### rtl/core/gnss_log_frame_sync_crc.sv
`timescale 1ns / 1ps

// Throughput: one byte per cycle while rsp_tready does not hold the output; the per-byte CRC step sets the cycle.
// Path: an accepted byte sits in the input register, and its result, if any, is captured in
//   the output register with rsp_tvalid high once that register is empty or taken.
// Reset (synchronous, active high) restores the register defaults, empties both
//   registers and starts the stream hunting for sync.

module gnss_log_frame_sync_crc #(
   parameter int MAX_BODY_LEN = 16384
) (
   input  logic                          clock,
   input  logic                          reset,
   // slave side
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [7:0] data_byte
   // master side
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [7:0] body_byte, [21:8] body_index, [37:22] message_id, [40:38] message_class,
   // [55:41] body_length, [71:56] gps_week, [103:72] week_milliseconds,
   // [105:104] frame_status, [111:106] zero
   output logic [111:0]                  rsp_tdata,
   output logic                          rsp_tuser,   // [0] item_kind
   // configuration
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [glfsc_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import glfsc_pkg::*;

   cfg_type     cfg;
   rsp_type     result;
   rsp_type     rsp_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        advance;
   logic        step;
   logic        emit;

   assign csr_pready = 1'b1;

   glfsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // Pipeline control: the output register frees when empty or taken
   assign advance      = !rsp_valid_ff || rsp_tready;
   assign step         = in_valid_ff && advance;
   assign req_tready   = !in_valid_ff || advance;
   assign rsp_valid_in = step && emit;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   glfsc_core #(
      .MAX_BODY_LEN (MAX_BODY_LEN)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_byte_ff),
      .cfg       (cfg),
      .emit      (emit),
      .result    (result)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tdata  = {6'h0, rsp_ff.status, rsp_ff.week_ms, rsp_ff.gps_week,
                        rsp_ff.body_length, rsp_ff.message_class, rsp_ff.message_id,
                        rsp_ff.body_index, rsp_ff.body_byte};

   // Checks
   a_ready_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled while the pipeline could move");

   a_body_status_good: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_BODY) |-> (rsp_tdata[105:104] == STAT_GOOD))
      else $error("body item carries a frame status");

   a_body_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_BODY) |->
         ({1'b0, rsp_tdata[21:8]} < rsp_tdata[55:41]))
      else $error("body index beyond body length");

   a_summary_empty_body: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_SUMMARY) |->
         (rsp_tdata[7:0] == 8'h0 && rsp_tdata[21:8] == 14'h0))
      else $error("summary carries body byte fields");

endmodule

### rtl/core/glfsc_csr.sv
`timescale 1ns / 1ps

module glfsc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [glfsc_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output glfsc_pkg::cfg_type            cfg
);
   import glfsc_pkg::*;

   localparam logic [31:0] SEED_RST = sync_seed(POLY_RST);

   logic [2:0]  reg_idx;
   logic        wr_en;
   logic [31:0] poly_ff;
   logic [31:0] seed_ff;
   logic [15:0] obs_ff;
   logic [15:0] gps_ff;
   logic [15:0] bds_ff;
   logic [15:0] iono_ff;

   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite;

   // Register writes; seed follows the polynomial in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RST;
         seed_ff <= SEED_RST;
         obs_ff  <= OBS_RST;
         gps_ff  <= GPS_RST;
         bds_ff  <= BDS_RST;
         iono_ff <= IONO_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_POLY: begin
               poly_ff <= pwdata;
               seed_ff <= sync_seed(pwdata);
            end
            REG_OBS:  obs_ff  <= pwdata[15:0];
            REG_GPS:  gps_ff  <= pwdata[15:0];
            REG_BDS:  bds_ff  <= pwdata[15:0];
            REG_IONO: iono_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      case (reg_idx)
         REG_POLY: prdata = poly_ff;
         REG_OBS:  prdata = {16'h0, obs_ff};
         REG_GPS:  prdata = {16'h0, gps_ff};
         REG_BDS:  prdata = {16'h0, bds_ff};
         REG_IONO: prdata = {16'h0, iono_ff};
         default:  prdata = 32'h0;
      endcase
   end

   assign cfg.poly    = poly_ff;
   assign cfg.seed    = seed_ff;
   assign cfg.obs_id  = obs_ff;
   assign cfg.gps_id  = gps_ff;
   assign cfg.bds_id  = bds_ff;
   assign cfg.iono_id = iono_ff;

endmodule

### rtl/core/glfsc_core.sv
`timescale 1ns / 1ps

module glfsc_core #(
   parameter int MAX_BODY_LEN = 16384
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          data_byte,
   input  glfsc_pkg::cfg_type  cfg,
   output logic                emit,
   output glfsc_pkg::rsp_type  result
);
   import glfsc_pkg::*;

   localparam int CNT_W = $clog2(MAX_BODY_LEN);
   localparam logic [CNT_W-1:0] HDR_LAST = CNT_W'(HEADER_LEN - 1);
   localparam logic [16:0] LEN_BOUND = 17'(MAX_BODY_LEN);

   phase_type        phase_ff, phase_in;
   logic [15:0]      hist_ff, hist_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0]      len_ff, len_in;
   logic [15:0]      id_ff, id_in;
   logic [15:0]      week_ff, week_in;
   logic [31:0]      ms_ff, ms_in;
   logic [31:0]      crc_ff, crc_in;
   logic [31:0]      rcv_ff, rcv_in;

   logic [31:0]      crc_next;
   logic             sync_hit;
   logic             body_done;
   logic [2:0]       cls;

   // One CRC byte step; the sync byte starts from the precomputed seed
   assign sync_hit  = (data_byte == SYNC2) && (hist_ff == {SYNC0, SYNC1});
   assign crc_next  = crc_byte((phase_ff == PH_HUNT) ? cfg.seed : crc_ff, data_byte, cfg.poly);
   assign body_done = (17'(cnt_ff) + 17'd1) >= {1'b0, len_ff};

   // Message class, lowest class wins on a tie
   always_comb begin
      if (id_ff == cfg.obs_id)       cls = CLASS_OBS;
      else if (id_ff == cfg.gps_id)  cls = CLASS_GPS;
      else if (id_ff == cfg.bds_id)  cls = CLASS_BDS;
      else if (id_ff == cfg.iono_id) cls = CLASS_IONO;
      else                           cls = CLASS_OTHER;
   end

   // Next state and result for the current byte
   always_comb begin
      phase_in = phase_ff;
      hist_in  = hist_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      id_in    = id_ff;
      week_in  = week_ff;
      ms_in    = ms_ff;
      crc_in   = crc_ff;
      rcv_in   = rcv_ff;
      emit     = 1'b0;

      result.kind          = KIND_SUMMARY;
      result.body_byte     = 8'h0;
      result.body_index    = 14'h0;
      result.message_id    = id_ff;
      result.message_class = cls;
      result.body_length   = (len_ff > 16'(LEN_SAT)) ? LEN_SAT : len_ff[14:0];
      result.gps_week      = week_ff;
      result.week_ms       = ms_ff;
      result.status        = STAT_GOOD;

      case (phase_ff)
         PH_HUNT: begin
            if (sync_hit) begin
               crc_in   = crc_next;
               cnt_in   = CNT_W'(3);
               len_in   = 16'h0;
               id_in    = 16'h0;
               week_in  = 16'h0;
               ms_in    = 32'h0;
               hist_in  = 16'h0;
               phase_in = PH_HEADER;
            end else begin
               hist_in = {hist_ff[7:0], data_byte};
            end
         end

         PH_HEADER: begin
            crc_in = crc_next;
            if (cnt_ff == CNT_W'(HDR_ID_LO))        id_in[7:0]    = data_byte;
            else if (cnt_ff == CNT_W'(HDR_ID_HI))   id_in[15:8]   = data_byte;
            else if (cnt_ff == CNT_W'(HDR_LEN_LO))  len_in[7:0]   = data_byte;
            else if (cnt_ff == CNT_W'(HDR_LEN_HI))  len_in[15:8]  = data_byte;
            else if (cnt_ff == CNT_W'(HDR_WEEK_LO)) week_in[7:0]  = data_byte;
            else if (cnt_ff == CNT_W'(HDR_WEEK_HI)) week_in[15:8] = data_byte;
            else if (cnt_ff inside {[HDR_MS_B0:HDR_MS_B3]}) begin
               ms_in[8*cnt_ff[1:0] +: 8] = data_byte;
            end

            if (cnt_ff == HDR_LAST) begin
               cnt_in = '0;
               rcv_in = 32'h0;
               if ({1'b0, len_ff} > LEN_BOUND) begin
                  phase_in      = PH_HUNT;
                  emit          = 1'b1;
                  result.status = STAT_LEN;
               end else begin
                  phase_in = (len_ff == 16'h0) ? PH_TRAILER : PH_BODY;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         PH_BODY: begin
            crc_in            = crc_next;
            emit              = 1'b1;
            result.kind       = KIND_BODY;
            result.body_byte  = data_byte;
            result.body_index = 14'(cnt_ff);
            if (body_done) begin
               cnt_in   = '0;
               rcv_in   = 32'h0;
               phase_in = PH_TRAILER;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         PH_TRAILER: begin
            rcv_in[8*cnt_ff[1:0] +: 8] = data_byte;
            if (cnt_ff[1:0] == 2'd3) begin
               cnt_in        = '0;
               hist_in       = 16'h0;
               phase_in      = PH_HUNT;
               emit          = 1'b1;
               result.status = (rcv_in == crc_ff) ? STAT_GOOD : STAT_CRC;
            end else begin
               cnt_in = CNT_W'(cnt_ff[1:0]) + 1'b1;
            end
         end

         default: begin
            phase_in = PH_HUNT;
            hist_in  = 16'h0;
            cnt_in   = '0;
         end
      endcase
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         hist_ff  <= 16'h0;
         cnt_ff   <= '0;
         len_ff   <= 16'h0;
         id_ff    <= 16'h0;
         week_ff  <= 16'h0;
         ms_ff    <= 32'h0;
         crc_ff   <= 32'h0;
         rcv_ff   <= 32'h0;
      end else if (step) begin
         phase_ff <= phase_in;
         hist_ff  <= hist_in;
         cnt_ff   <= cnt_in;
         len_ff   <= len_in;
         id_ff    <= id_in;
         week_ff  <= week_in;
         ms_ff    <= ms_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
      end
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import glfsc_pkg::*;

   localparam int MAX_BODY     = 16384;
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_BYTES  = 40;
   localparam int PHASE_FRAMES = 1;

   // Indexes past the register map; writes there must be ignored
   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   // One directed row: optional lead-in bytes, then optionally one frame
   typedef struct packed {
      logic [31:0] lead;      // lead-in bytes, low byte sent first
      logic [2:0]  lead_n;
      logic        framed;
      logic [15:0] id;
      logic [15:0] len;
      logic [15:0] week;
      logic [31:0] ms;
      logic [7:0]  hdr_len;
      logic        bad_crc;
      logic        typed;     // summary below is the expected one
      logic [2:0]  cls;
      logic [1:0]  st;
   } stim_row_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata   = 8'h00;    // [7:0] data_byte
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   // [7:0] body_byte, [21:8] body_index, [37:22] message_id, [40:38] message_class,
   // [55:41] body_length, [71:56] gps_week, [103:72] week_milliseconds,
   // [105:104] frame_status, [111:106] zero
   logic [111:0] rsp_tdata;
   logic         rsp_tuser;              // [0] item_kind
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]  csr_pwdata  = 32'h0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   // Register shadows
   logic [31:0] poly_sh = POLY_RST;
   logic [15:0] obs_sh  = OBS_RST;
   logic [15:0] gps_sh  = GPS_RST;
   logic [15:0] bds_sh  = BDS_RST;
   logic [15:0] iono_sh = IONO_RST;

   // Deframer state mirror
   phase_type   fr_phase  = PH_HUNT;
   logic [15:0] sync_hist = '0;
   logic [15:0] byte_cnt  = '0;
   logic [15:0] len_h     = '0;
   logic [15:0] id_h      = '0;
   logic [15:0] week_h    = '0;
   logic [31:0] ms_h      = '0;
   logic [31:0] run_crc   = '0;
   logic [31:0] rx_crc    = '0;

   rsp_type      expected_reports [$];
   stim_row_type dir_rows [14];

   int send_idle   = 0;
   int recv_stall  = 0;
   int fail_count  = 0;
   int cycle_count = 0;
   int bytes_sent  = 0;
   int frames_sent = 0;
   int body_seen   = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   gnss_log_frame_sync_crc #(.MAX_BODY_LEN(MAX_BODY)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // Reflected CRC-32 over one byte, LSB first
   function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
      logic [31:0] x;
      x = crc ^ {24'h0, b};
      repeat (8) x = x[0] ? ((x >> 1) ^ poly_sh) : (x >> 1);
      return x;
   endfunction

   // Lowest matching class wins a tie
   function automatic logic [2:0] msg_class(logic [15:0] id);
      if (id == obs_sh) return CLASS_OBS;
      if (id == gps_sh) return CLASS_GPS;
      if (id == bds_sh) return CLASS_BDS;
      if (id == iono_sh) return CLASS_IONO;
      return CLASS_OTHER;
   endfunction

   function automatic rsp_type make_report(logic kind, logic [7:0] b, logic [13:0] idx,
                                           logic [1:0] st);
      rsp_type r;
      r.kind          = kind;
      r.body_byte     = b;
      r.body_index    = idx;
      r.message_id    = id_h;
      r.message_class = msg_class(id_h);
      r.body_length   = (len_h > LEN_SAT) ? LEN_SAT : len_h[14:0];
      r.gps_week      = week_h;
      r.week_ms       = ms_h;
      r.status        = st;
      return r;
   endfunction

   // Advance the deframer mirror by one accepted byte, queue what it emits
   task automatic deframe_byte(input logic [7:0] b);
      logic [15:0] c;
      c = byte_cnt;
      case (fr_phase)
         PH_HUNT: begin
            if (b == SYNC2 && sync_hist == {SYNC0, SYNC1}) begin
               run_crc   = crc_step(crc_step(crc_step(32'h0, SYNC0), SYNC1), SYNC2);
               byte_cnt  = 16'd3;
               len_h     = '0;
               id_h      = '0;
               week_h    = '0;
               ms_h      = '0;
               sync_hist = '0;
               fr_phase  = PH_HEADER;
            end else begin
               sync_hist = {sync_hist[7:0], b};
            end
         end
         PH_HEADER: begin
            run_crc = crc_step(run_crc, b);
            if (c == HDR_ID_LO) id_h[7:0] = b;
            else if (c == HDR_ID_HI) id_h[15:8] = b;
            else if (c == HDR_LEN_LO) len_h[7:0] = b;
            else if (c == HDR_LEN_HI) len_h[15:8] = b;
            else if (c == HDR_WEEK_LO) week_h[7:0] = b;
            else if (c == HDR_WEEK_HI) week_h[15:8] = b;
            else if (c >= HDR_MS_B0 && c <= HDR_MS_B3) ms_h[8*(c-HDR_MS_B0) +: 8] = b;
            if (c + 1 >= HEADER_LEN) begin
               byte_cnt = '0;
               if (len_h > MAX_BODY) begin
                  // over the bound: report at once, no body or trailer
                  fr_phase = PH_HUNT;
                  expected_reports.push_back(make_report(KIND_SUMMARY, 8'h0, 14'h0, STAT_LEN));
               end else begin
                  rx_crc = '0;
                  if (len_h == 0) fr_phase = PH_TRAILER;
                  else fr_phase = PH_BODY;
               end
            end else begin
               byte_cnt = c + 16'd1;
            end
         end
         PH_BODY: begin
            run_crc = crc_step(run_crc, b);
            expected_reports.push_back(make_report(KIND_BODY, b, c[13:0], STAT_GOOD));
            if (c + 1 >= len_h) begin
               byte_cnt = '0;
               rx_crc   = '0;
               fr_phase = PH_TRAILER;
            end else begin
               byte_cnt = c + 16'd1;
            end
         end
         default: begin
            rx_crc[8*c[1:0] +: 8] = b;
            if (c[1:0] == 2'd3) begin
               byte_cnt  = '0;
               fr_phase  = PH_HUNT;
               sync_hist = '0;
               expected_reports.push_back(make_report(KIND_SUMMARY, 8'h0, 14'h0,
                                          (rx_crc == run_crc) ? STAT_GOOD : STAT_CRC));
            end else begin
               byte_cnt = {14'h0, c[1:0]} + 16'd1;
            end
         end
      endcase
   endtask

   // Send one byte, with random idle cycles ahead of it
   task automatic push_byte(input logic [7:0] b);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      deframe_byte(b);
      bytes_sent++;
   endtask

   // Pause the sender until every expected item is back and the pipe is quiet
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   // Result monitor
   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind          = rsp_tuser;
         got.body_byte     = rsp_tdata[7:0];
         got.body_index    = rsp_tdata[21:8];
         got.message_id    = rsp_tdata[37:22];
         got.message_class = rsp_tdata[40:38];
         got.body_length   = rsp_tdata[55:41];
         got.gps_week      = rsp_tdata[71:56];
         got.week_ms       = rsp_tdata[103:72];
         got.status        = rsp_tdata[105:104];
         if (expected_reports.size() == 0) begin
            $error("unexpected result item, kind %0d", got.kind);
            fail_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("item_kind", 32'(want.kind), 32'(got.kind));
            check_field("body_byte", 32'(want.body_byte), 32'(got.body_byte));
            check_field("body_index", 32'(want.body_index), 32'(got.body_index));
            check_field("message_id", 32'(want.message_id), 32'(got.message_id));
            check_field("message_class", 32'(want.message_class), 32'(got.message_class));
            check_field("body_length", 32'(want.body_length), 32'(got.body_length));
            check_field("gps_week", 32'(want.gps_week), 32'(got.gps_week));
            check_field("week_milliseconds", want.week_ms, got.week_ms);
            check_field("frame_status", 32'(want.status), 32'(got.status));
            if (got.kind == KIND_BODY) body_seen++;
            else status_seen[got.status]++;
         end
      end
   end

   function automatic logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
         REG_POLY: return poly_sh;
         REG_OBS:  return {16'h0, obs_sh};
         REG_GPS:  return {16'h0, gps_sh};
         REG_BDS:  return {16'h0, bds_sh};
         REG_IONO: return {16'h0, iono_sh};
         default:  return 32'h0;
      endcase
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_POLY: poly_sh = val;
         REG_OBS:  obs_sh  = val[15:0];
         REG_GPS:  gps_sh  = val[15:0];
         REG_BDS:  bds_sh  = val[15:0];
         REG_IONO: iono_sh = val[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [2:0] idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("csr_prdata", reg_value(idx), csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] poly, input logic [15:0] obs,
                                input logic [15:0] gps, input logic [15:0] bds,
                                input logic [15:0] iono);
      csr_write(REG_POLY, poly);
      csr_write(REG_OBS, {16'h0, obs});
      csr_write(REG_GPS, {16'h0, gps});
      csr_write(REG_BDS, {16'h0, bds});
      csr_write(REG_IONO, {16'h0, iono});
      for (int i = REG_POLY; i <= REG_IONO; i++) csr_read_check(3'(i));
   endtask

   function automatic logic [7:0] header_byte(int p, logic [15:0] id, logic [15:0] len,
                                              logic [15:0] week, logic [31:0] ms,
                                              logic [7:0] hdr_len);
      if (p == 0) return SYNC0;
      if (p == 1) return SYNC1;
      if (p == 2) return SYNC2;
      if (p == 3) return hdr_len;
      if (p == HDR_ID_LO) return id[7:0];
      if (p == HDR_ID_HI) return id[15:8];
      if (p == HDR_LEN_LO) return len[7:0];
      if (p == HDR_LEN_HI) return len[15:8];
      if (p == HDR_WEEK_LO) return week[7:0];
      if (p == HDR_WEEK_HI) return week[15:8];
      if (p >= HDR_MS_B0 && p <= HDR_MS_B3) return ms[8*(p-HDR_MS_B0) +: 8];
      return 8'($urandom);
   endfunction

   // Whole frame: header, then, if the length is within the bound, random body and little-endian CRC trailer
   task automatic send_frame(input logic [15:0] id, input logic [15:0] len,
                             input logic [15:0] week, input logic [31:0] ms,
                             input logic [7:0] hdr_len, input logic bad_crc);
      logic [7:0]  b;
      logic [31:0] crc;
      crc = 32'h0;
      for (int p = 0; p < HEADER_LEN; p++) begin
         b   = header_byte(p, id, len, week, ms, hdr_len);
         crc = crc_step(crc, b);
         push_byte(b);
      end
      if (len <= MAX_BODY) begin
         for (int i = 0; i < len; i++) begin
            b   = 8'($urandom);
            crc = crc_step(crc, b);
            push_byte(b);
         end
         if (bad_crc) crc = crc ^ (32'h1 << $urandom_range(31));
         for (int k = 0; k < 4; k++) push_byte(crc[8*k +: 8]);
      end
      frames_sent++;
   endtask

   function automatic rsp_type typed_summary(stim_row_type row);
      rsp_type s;
      s               = '0;
      s.kind          = KIND_SUMMARY;
      s.message_id    = row.id;
      s.message_class = row.cls;
      s.body_length   = (row.len > LEN_SAT) ? LEN_SAT : row.len[14:0];
      s.gps_week      = row.week;
      s.week_ms       = row.ms;
      s.status        = row.st;
      return s;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(4))
         0:       return SYNC0;
         1:       return SYNC1;
         2:       return SYNC2;
         default: return 8'($urandom);
      endcase
   endfunction

   // One random chunk of stream: mostly frames, some noise and broken ones
   task automatic random_unit();
      int          pick;
      int          r;
      int          n;
      logic [15:0] id;
      logic [15:0] len;
      logic [7:0]  b;
      pick = $urandom_range(99);
      if (pick < 70) begin
         case ($urandom_range(6))
            0:       id = obs_sh;
            1:       id = gps_sh;
            2:       id = bds_sh;
            3:       id = iono_sh;
            4:       id = 16'h0000;
            5:       id = 16'hFFFF;
            default: id = 16'($urandom);
         endcase
         r = $urandom_range(99);
         if (r < 55) len = 16'($urandom_range(0, 8));
         else if (r < 82) len = 16'($urandom_range(9, 40));
         else if (r < 90) len = 16'($urandom_range(41, 64));
         else len = 16'($urandom_range(MAX_BODY + 1, 65535));
         send_frame(id, len, 16'(pick_word()), pick_word(), 8'($urandom),
                    $urandom_range(99) < 25);
      end else if (pick < 82) begin
         repeat ($urandom_range(1, 6)) push_byte(noise_byte());
      end else if (pick < 90) begin
         // sync with a wrong third byte
         push_byte(SYNC0);
         push_byte(SYNC1);
         do b = 8'($urandom); while (b == SYNC2);
         push_byte(b);
      end else if (pick < 97) begin
         // frame cut short inside the header; a short length keeps the tail brief
         push_byte(SYNC0);
         push_byte(SYNC1);
         push_byte(SYNC2);
         n = $urandom_range(7, 24);
         for (int q = 3; q < 3 + n; q++) begin
            if (q == HDR_LEN_LO) push_byte({3'b000, 5'($urandom)});
            else if (q == HDR_LEN_HI) push_byte(8'h00);
            else push_byte(noise_byte());
         end
      end else begin
         wait_drained();
      end
   endtask

   initial begin : stimulus
      int          idle_send [4];
      int          idle_recv [4];
      int          phase_start_bytes;
      int          phase_start_frames;
      logic [15:0] tie_id;

      idle_send = '{0, 55, 0, 24};
      idle_recv = '{0, 0, 55, 24};

      //   lead-in        n     frame id        len        week       ms            hlen
      //   bad   typed class        status
      dir_rows = '{
         '{32'h0,        3'd0, 1'b1, 16'd43,   16'd4,     16'd0,     32'h0,        8'd28,
           1'b0, 1'b1, CLASS_OBS,   STAT_GOOD},
         '{32'h0,        3'd0, 1'b1, 16'd7,    16'd1,     16'hFFFF,  32'hFFFF_FFFF, 8'd0,
           1'b0, 1'b1, CLASS_GPS,   STAT_GOOD},
         // zero length: trailer right after the header
         '{32'h0,        3'd0, 1'b1, 16'd1696, 16'd0,     16'd1,     32'h1,        8'hFF,
           1'b0, 1'b1, CLASS_BDS,   STAT_GOOD},
         '{32'h0,        3'd0, 1'b1, 16'd8,    16'd3,     16'd2048,  32'd604799999, 8'd28,
           1'b1, 1'b1, CLASS_IONO,  STAT_CRC},
         '{32'h0,        3'd0, 1'b1, 16'hFFFF, 16'd2,     16'h8000,  32'h8000_0000, 8'd1,
           1'b0, 1'b1, CLASS_OTHER, STAT_GOOD},
         '{32'h0,        3'd0, 1'b1, 16'h0000, 16'd1,     16'h00FF,  32'h0000_00FF, 8'd28,
           1'b0, 1'b1, CLASS_OTHER, STAT_GOOD},
         // just over the length bound
         '{32'h0,        3'd0, 1'b1, 16'd7,    16'd16385, 16'd100,   32'd5000,     8'd28,
           1'b0, 1'b1, CLASS_GPS,   STAT_LEN},
         // widest length, saturates in the report
         '{32'h0,        3'd0, 1'b1, 16'd43,   16'hFFFF,  16'hFFFF,  32'hFFFF_FFFF, 8'd28,
           1'b0, 1'b1, CLASS_OBS,   STAT_LEN},
         '{32'h0,        3'd0, 1'b1, 16'h1234, 16'h8000,  16'd0,     32'h0,        8'd28,
           1'b0, 1'b1, CLASS_OTHER, STAT_LEN},
         // false sync ahead of a real one
         '{32'h001344AA, 3'd3, 1'b1, 16'h0100, 16'd5,     16'd9,     32'd77,       8'd28,
           1'b0, 1'b0, CLASS_OTHER, STAT_GOOD},
         // overlapping sync prefix
         '{32'h00AA44AA, 3'd3, 1'b1, 16'd8,    16'd6,     16'd10,    32'd78,       8'd28,
           1'b0, 1'b0, CLASS_IONO,  STAT_GOOD},
         // noise only
         '{32'h12AA1244, 3'd4, 1'b0, 16'h0,    16'd0,     16'd0,     32'h0,        8'd0,
           1'b0, 1'b0, CLASS_OTHER, STAT_GOOD},
         // longer body at the reset ids
         '{32'h0,        3'd0, 1'b1, 16'd43,   16'd64,    16'd2200,  32'd123456,   8'd28,
           1'b0, 1'b1, CLASS_OBS,   STAT_GOOD},
         '{32'h0,        3'd0, 1'b1, 16'd7,    16'd0,     16'd3,     32'd3,        8'd28,
           1'b1, 1'b1, CLASS_GPS,   STAT_CRC}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = REG_POLY; i <= REG_IONO; i++) csr_read_check(3'(i));

      // Directed rows at reset settings, no idling
      foreach (dir_rows[r]) begin
         for (int k = 0; k < dir_rows[r].lead_n; k++) push_byte(dir_rows[r].lead[8*k +: 8]);
         if (dir_rows[r].framed) begin
            send_frame(dir_rows[r].id, dir_rows[r].len, dir_rows[r].week, dir_rows[r].ms,
                       dir_rows[r].hdr_len, dir_rows[r].bad_crc);
            if (dir_rows[r].typed)
               expected_reports[expected_reports.size()-1] = typed_summary(dir_rows[r]);
         end
      end
      wait_drained();

      // Random phases, each under its own register setting and idle pattern
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: apply_setting(32'h82F6_3B78, 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom));
            1: begin
               apply_setting(32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
               csr_write(REG_SPARE_LO, $urandom);
               csr_write(REG_SPARE_HI, $urandom);
               for (int i = REG_POLY; i <= REG_IONO; i++) csr_read_check(3'(i));
            end
            2: begin
               // every id register equal: the lowest class must win
               tie_id = 16'($urandom);
               apply_setting(32'h0, tie_id, tie_id, tie_id, tie_id);
            end
            default: apply_setting(POLY_RST, 16'($urandom), 16'($urandom),
                                   16'($urandom), 16'($urandom));
         endcase
         send_idle          = idle_send[p];
         recv_stall         = idle_recv[p];
         phase_start_bytes  = bytes_sent;
         phase_start_frames = frames_sent;
         while (bytes_sent - phase_start_bytes < PHASE_BYTES ||
                frames_sent - phase_start_frames < PHASE_FRAMES)
            random_unit();
         // finish any frame in flight before touching the registers
         while (fr_phase != PH_HUNT) push_byte(8'($urandom));
         wait_drained();
      end

      $display("Covered %0d input bytes, %0d built frames, directed rows and 4 register settings",
               bytes_sent, frames_sent);
      $display("Checked %0d body items and summaries: %0d good, %0d crc, %0d over-length",
               body_seen, status_seen[STAT_GOOD], status_seen[STAT_CRC], status_seen[STAT_LEN]);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
